// ----- src/bws_pkg.sv -----
// Shared types, constants and coefficient tables for the band-limited waveform sampler.
package bws_pkg;

  // Waveform commands
  localparam logic [2:0] CMD_SINE     = 3'd0;
  localparam logic [2:0] CMD_TRIANGLE = 3'd1;
  localparam logic [2:0] CMD_SAW_UP   = 3'd2;
  localparam logic [2:0] CMD_SAW_DOWN = 3'd3;
  localparam logic [2:0] CMD_PULSE    = 3'd4;
  localparam logic [2:0] CMD_SQUARE   = 3'd5;

  // Series kinds
  localparam logic [1:0] KIND_TRI = 2'd0;
  localparam logic [1:0] KIND_SAW = 2'd1;
  localparam logic [1:0] KIND_SQR = 2'd2;

  // Shared multiplier operand width
  localparam int MUL_W = 32;
  // Magnitude width of a sine value (Q30, at most 1.0)
  localparam int DVD_W = 31;
  // Running sum width, signed
  localparam int ACC_W = 40;
  // Width of the running 2*h*f value; it never exceeds 2^29
  localparam int HF_W  = 29;

  // Scale constants, Q30
  localparam logic [30:0] ONE_Q30 = 31'd1073741824;
  localparam logic [30:0] K_TRI   = 31'd870342350;
  localparam logic [30:0] K_SAW   = 31'd683565275;
  localparam logic [30:0] K_SQR   = 31'd1367130551;

  // Pulse width limits, Q0.16
  localparam logic [15:0] PW_HALF = 16'd32768;
  localparam logic [15:0] PW_MIN  = 16'd3277;
  localparam logic [15:0] PW_MAX  = 16'd62259;

  // Sample clamp limits, Q3.20
  localparam logic [31:0] SAT_POS = 32'd8388607;
  localparam logic [31:0] SAT_NEG = 32'd8388608;

  // Polynomial constant at each Horner step (step 1 to 5), from which the product is subtracted
  function automatic logic [31:0] horner_coef(input logic [2:0] step);
    logic [31:0] c;
    unique case (step)
      3'd1:    c = 32'd172271;
      3'd2:    c = 32'd5026995;
      3'd3:    c = 32'd85569306;
      3'd4:    c = 32'd693598668;
      3'd5:    c = 32'd1686629713;
      default: c = 32'd0;
    endcase
    return c;
  endfunction

endpackage

// ----- src/bws_mul.sv -----
// Shared unsigned 32 by 32 multiplier of the sampler datapath.
module bws_mul (
  input  logic [bws_pkg::MUL_W-1:0]   a,
  input  logic [bws_pkg::MUL_W-1:0]   b,
  output logic [2*bws_pkg::MUL_W-1:0] p
);

  // Form the full product
  assign p = {{bws_pkg::MUL_W{1'b0}}, a} * {{bws_pkg::MUL_W{1'b0}}, b};

endmodule

// ----- src/bws_div.sv -----
// Bit-serial restoring divider for one harmonic term magnitude.
module bws_div #(
  parameter int DVS_W = 30
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [bws_pkg::DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0]          divisor,
  output logic                      done,
  output logic [bws_pkg::DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(bws_pkg::DVD_W + 1);

  logic [DVS_W-1:0]          rem;
  logic [DVS_W-1:0]          rem_next;
  logic [bws_pkg::DVD_W-1:0] quo;
  logic [CNT_W-1:0]          cnt;
  logic [DVS_W:0]            rem_sh;
  logic                      ge;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    rem_sh = {rem, quo[bws_pkg::DVD_W-1]};
    ge     = rem_sh >= {1'b0, divisor};
    if (ge) begin
      rem_next = DVS_W'(rem_sh - {1'b0, divisor});
    end else begin
      rem_next = rem_sh[DVS_W-1:0];
    end
  end

  // Advance one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem <= '0;
        quo <= dividend;
        cnt <= CNT_W'(bws_pkg::DVD_W);
      end else if (cnt != '0) begin
        rem <= rem_next;
        quo <= {quo[bws_pkg::DVD_W-2:0], ge};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

// ----- src/bandlimited_waveform_sample.sv -----
// Top level of the band-limited waveform sampler: sequencer, sine polynomial and series sum.
//
// One command returns one band-limited sample, built by summing Fourier harmonics below
// Nyquist on one shared multiplier and a bit-serial divider. busy is high from the transfer
// of a command until its result strobe; done marks the sample for exactly one cycle and the
// receiver cannot stall it. Each harmonic takes 7 multiplies of the sine polynomial, a
// divide of the term by h or h*h, plus check and accumulate. Each series sums the
// harmonics below sample_rate / 2, at most MAX_HARMONICS per series; pulse at widths other
// than one half runs two series. Sine evaluates the polynomial alone and the unused
// commands give a zero sample. sample_rate is written by sample_rate_we; the user must
// write it only while busy is low, as the block itself does not enforce this.
module bandlimited_waveform_sample #(
  parameter int MAX_HARMONICS   = 1024,
  parameter int SINE_TABLE_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command,
  input  logic [23:0] phase,
  input  logic [25:0] frequency,
  input  logic [15:0] pulse_width,
  input  logic        sample_rate_we,
  input  logic [18:0] sample_rate,
  output logic        done,
  output logic [23:0] sample,
  output logic        harmonics_capped
);

  localparam int H_W   = $clog2(2 * MAX_HARMONICS + 2);
  localparam int N_W   = $clog2(MAX_HARMONICS + 1);
  localparam int DVS_W = 2 * H_W;
  localparam int TB    = SINE_TABLE_BITS;
  localparam int MW    = bws_pkg::MUL_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_SIN   = 4'd2;
  localparam logic [3:0] S_HH    = 4'd3;
  localparam logic [3:0] S_DIVS  = 4'd4;
  localparam logic [3:0] S_DIVW  = 4'd5;
  localparam logic [3:0] S_ACC   = 4'd6;
  localparam logic [3:0] S_FIN0  = 4'd7;
  localparam logic [3:0] S_FIN1  = 4'd8;
  localparam logic [3:0] S_FIN2  = 4'd9;

  logic [3:0]               state;
  logic [18:0]              sr;
  logic [1:0]               kind;
  logic                     step2;
  logic                     pulse_two;
  logic                     second;
  logic                     sine_only;
  logic [30:0]              coef;
  logic                     coef_neg;
  logic [23:0]              ph_base;
  logic [23:0]              ph_base2;
  logic [25:0]              fr;
  logic [N_W-1:0]           n;
  logic [H_W-1:0]           h;
  logic [bws_pkg::HF_W-1:0] hf2;
  logic [23:0]              ph_acc;
  logic [30:0]              q;
  logic [30:0]              q2;
  logic [31:0]              t;
  logic                     sneg;
  logic [30:0]              s_mag;
  logic [DVS_W-1:0]         hh;
  logic signed [bws_pkg::ACC_W-1:0] acc;
  logic                     capped;
  logic [71:0]              prod;
  logic [2:0]               sstep;

  logic [MW-1:0]            mul_a;
  logic [MW-1:0]            mul_b;
  logic [2*MW-1:0]          mp;
  logic [33:0]              mp_sh;
  logic                     div_start;
  logic                     div_done;
  logic [bws_pkg::DVD_W-1:0] div_q;
  logic [DVS_W-1:0]         divisor;

  logic [23:0]              sin_ph;
  logic [TB-1:0]            idx;
  logic [30:0]              q_raw;
  logic [30:0]              q_in;
  logic                     neg_in;
  logic                     accept;
  logic                     nyq_ok;
  logic [15:0]              pw_cl;
  logic [22:0]              off;
  logic signed [bws_pkg::ACC_W-1:0] term;
  logic                     sub;
  logic [bws_pkg::ACC_W-2:0] amag;
  logic                     out_neg;
  logic [31:0]              rnd;
  logic [71:0]              rnd_full;

  assign accept = start && !busy;
  assign busy   = state != S_IDLE;

  // Derive the quarter-wave argument and sign from a phase
  assign sin_ph = (state == S_IDLE) ? phase : ph_acc;
  always_comb begin
    idx    = sin_ph[23 -: TB];
    q_raw  = 31'(idx[TB-3:0]) << (32 - TB);
    q_in   = idx[TB-2] ? 31'(bws_pkg::ONE_Q30 - q_raw) : q_raw;
    neg_in = idx[TB-1];
  end

  // Clamp the pulse width and form the saw offset
  always_comb begin
    pw_cl = pulse_width;
    if (pw_cl < bws_pkg::PW_MIN) begin
      pw_cl = bws_pkg::PW_MIN;
    end
    if (pw_cl > bws_pkg::PW_MAX) begin
      pw_cl = bws_pkg::PW_MAX;
    end
    off = {pw_cl, 7'd0};
  end

  assign nyq_ok = hf2 < bws_pkg::HF_W'({sr, 8'd0});

  // Final magnitude and sign of the sum times the scale constant
  always_comb begin
    amag    = acc[bws_pkg::ACC_W-1] ? (bws_pkg::ACC_W-1)'(-acc)
                                    : acc[bws_pkg::ACC_W-2:0];
    out_neg = acc[bws_pkg::ACC_W-1] ^ coef_neg;
    rnd_full = prod + (72'd1 << 39);
    rnd      = rnd_full[71:40];
  end

  // Select the shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_SIN: begin
        mul_a = (sstep == 3'd0 || sstep == 3'd6) ? MW'(q) : MW'(q2);
        if (sstep == 3'd0) begin
          mul_b = MW'(q);
        end else if (sstep == 3'd1) begin
          mul_b = 32'd3864;
        end else begin
          mul_b = t;
        end
      end
      S_HH: begin
        mul_a = MW'(h);
        mul_b = MW'(h);
      end
      S_FIN0: begin
        mul_a = MW'(amag[19:0]);
        mul_b = MW'(coef);
      end
      S_FIN1: begin
        mul_a = MW'(amag[bws_pkg::ACC_W-2:20]);
        mul_b = MW'(coef);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  bws_mul u_mul (
    .a (mul_a),
    .b (mul_b),
    .p (mp)
  );

  assign mp_sh = mp[63:30];

  assign divisor   = (kind == bws_pkg::KIND_TRI) ? hh : DVS_W'(h);
  assign div_start = state == S_DIVS;

  bws_div #(
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (s_mag),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // Signed term and whether it is subtracted
  always_comb begin
    term = sneg ? -$signed({{(bws_pkg::ACC_W-31){1'b0}}, div_q})
                : $signed({{(bws_pkg::ACC_W-31){1'b0}}, div_q});
    sub  = ((kind == bws_pkg::KIND_TRI) && n[0]) || ((kind == bws_pkg::KIND_SAW) && h[0]);
    sub  = sub ^ second;
  end

  // Hold the sample rate register
  always_ff @(posedge clk) begin
    if (rst) begin
      sr <= 19'd48000;
    end else if (sample_rate_we) begin
      sr <= sample_rate;
    end
  end

  // Sequence commands through harmonics, divide and scaling
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            n         <= '0;
            h         <= H_W'(1);
            hf2       <= bws_pkg::HF_W'({frequency, 1'b0});
            fr        <= frequency;
            ph_acc    <= phase;
            ph_base   <= phase;
            ph_base2  <= phase;
            acc       <= '0;
            capped    <= 1'b0;
            second    <= 1'b0;
            pulse_two <= 1'b0;
            sine_only <= 1'b0;
            step2     <= 1'b1;
            kind      <= bws_pkg::KIND_SQR;
            coef      <= bws_pkg::ONE_Q30;
            coef_neg  <= 1'b0;
            state     <= S_CHECK;
            unique case (command)
              bws_pkg::CMD_SINE: begin
                sine_only <= 1'b1;
                q         <= q_in;
                sneg      <= neg_in;
                sstep     <= 3'd0;
                state     <= S_SIN;
              end
              bws_pkg::CMD_TRIANGLE: begin
                kind <= bws_pkg::KIND_TRI;
                coef <= bws_pkg::K_TRI;
              end
              bws_pkg::CMD_SAW_UP: begin
                kind     <= bws_pkg::KIND_SAW;
                step2    <= 1'b0;
                coef     <= bws_pkg::K_SAW;
                coef_neg <= 1'b1;
              end
              bws_pkg::CMD_SAW_DOWN: begin
                kind  <= bws_pkg::KIND_SAW;
                step2 <= 1'b0;
                coef  <= bws_pkg::K_SAW;
              end
              bws_pkg::CMD_PULSE: begin
                if (pulse_width == bws_pkg::PW_HALF) begin
                  coef <= bws_pkg::K_SQR;
                end else begin
                  kind      <= bws_pkg::KIND_SAW;
                  step2     <= 1'b0;
                  coef      <= bws_pkg::K_SAW;
                  coef_neg  <= 1'b1;
                  pulse_two <= 1'b1;
                  ph_acc    <= phase + {1'b0, off};
                  ph_base   <= phase + {1'b0, off};
                  ph_base2  <= phase - {1'b0, off};
                end
              end
              bws_pkg::CMD_SQUARE: begin
                coef <= bws_pkg::K_SQR;
              end
              default: begin
                state <= S_FIN0;
              end
            endcase
          end
        end
        S_CHECK: begin
          if (!nyq_ok || n == N_W'(MAX_HARMONICS)) begin
            if (nyq_ok) begin
              capped <= 1'b1;
            end
            if (pulse_two && !second) begin
              // Start the second, subtracted saw series
              second  <= 1'b1;
              n       <= '0;
              h       <= H_W'(1);
              hf2     <= bws_pkg::HF_W'({fr, 1'b0});
              ph_acc  <= ph_base2;
              ph_base <= ph_base2;
            end else begin
              state <= S_FIN0;
            end
          end else begin
            q     <= q_in;
            sneg  <= neg_in;
            sstep <= 3'd0;
            state <= S_SIN;
          end
        end
        S_SIN: begin
          sstep <= sstep + 3'd1;
          if (sstep == 3'd0) begin
            q2 <= mp_sh[30:0];
          end else if (sstep != 3'd6) begin
            t <= bws_pkg::horner_coef(sstep) - mp_sh[31:0];
          end else begin
            s_mag <= mp_sh[30:0];
            if (sine_only) begin
              acc   <= sneg ? -$signed({{(bws_pkg::ACC_W-31){1'b0}}, mp_sh[30:0]})
                            : $signed({{(bws_pkg::ACC_W-31){1'b0}}, mp_sh[30:0]});
              state <= S_FIN0;
            end else if (kind == bws_pkg::KIND_TRI) begin
              state <= S_HH;
            end else begin
              state <= S_DIVS;
            end
          end
        end
        S_HH: begin
          hh    <= mp[DVS_W-1:0];
          state <= S_DIVS;
        end
        S_DIVS: begin
          state <= S_DIVW;
        end
        S_DIVW: begin
          if (div_done) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          // Add the term and advance to the next harmonic
          acc    <= sub ? acc - term : acc + term;
          n      <= n + N_W'(1);
          h      <= step2 ? h + H_W'(2) : h + H_W'(1);
          hf2    <= step2 ? hf2 + bws_pkg::HF_W'({fr, 2'd0})
                          : hf2 + bws_pkg::HF_W'({fr, 1'b0});
          ph_acc <= step2 ? ph_acc + {ph_base[22:0], 1'b0} : ph_acc + ph_base;
          state  <= S_CHECK;
        end
        S_FIN0: begin
          prod  <= 72'(mp);
          state <= S_FIN1;
        end
        S_FIN1: begin
          prod  <= prod + (72'(mp) << 20);
          state <= S_FIN2;
        end
        S_FIN2: begin
          // Round, saturate and present the sample
          if (out_neg) begin
            sample <= (rnd >= bws_pkg::SAT_NEG) ? 24'h800000 : 24'(-rnd);
          end else begin
            sample <= (rnd > bws_pkg::SAT_POS) ? 24'h7FFFFF : rnd[23:0];
          end
          harmonics_capped <= capped;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/bws_checker.sv -----
// Port-level assertions for the band-limited waveform sampler and their bind.
module bws_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // A result strobe ends the busy period
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // A command transfer makes the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("command transfer did not raise busy");

  // Strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held");

  // Busy only drops together with a result
  a_busy_fall: assert property (@(posedge clk) disable iff (rst) $fell(busy) |-> done)
    else $error("busy dropped without a result");

endmodule

bind bandlimited_waveform_sample bws_checker u_bws_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

// ----- bench/tb.sv -----
// Self-checking testbench for the band-limited waveform sampler.
`timescale 1ns / 100ps

module tb;

  localparam int MAX_H = 1024;
  localparam int TBITS = 12;
  localparam bit [63:0] PH_MASK = 64'hFFFFFF;

  typedef struct {
    logic [2:0]  cmd;
    logic [23:0] ph;
    logic [25:0] freq;
    logic [15:0] pw;
  } wave_item_t;

  typedef struct {
    logic [23:0] value;
    logic        capped;
  } wave_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [2:0]  command = '0;
  logic [23:0] phase = '0;
  logic [25:0] frequency = '0;
  logic [15:0] pulse_width = '0;
  logic        sample_rate_we = 1'b0;
  logic [18:0] sample_rate = '0;
  logic        done;
  logic [23:0] sample;
  logic        harmonics_capped;

  wave_item_t   pending_items[$];
  wave_result_t expected_samples[$];
  wave_item_t   cur_item;
  bit [18:0]    rate_mirror = 19'd48000;
  bit           no_gaps = 1'b0;
  int           mismatches = 0;

  bandlimited_waveform_sample dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .phase(phase), .frequency(frequency),
    .pulse_width(pulse_width), .sample_rate_we(sample_rate_we),
    .sample_rate(sample_rate), .done(done), .sample(sample),
    .harmonics_capped(harmonics_capped)
  );

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sin(pi/2 * q), q in Q30
  function automatic bit [63:0] quarter_sine_q30(bit [63:0] q);
    bit [63:0] q2, t;
    q2 = (q * q) >> 30;
    t = 64'd172271 - ((q2 * 64'd3864) >> 30);
    t = 64'd5026995 - ((q2 * t) >> 30);
    t = 64'd85569306 - ((q2 * t) >> 30);
    t = 64'd693598668 - ((q2 * t) >> 30);
    t = 64'd1686629713 - ((q2 * t) >> 30);
    return (q * t) >> 30;
  endfunction

  // Sine of a Q0.24 phase, Q30 signed
  function automatic longint sine_q30(bit [23:0] ph);
    bit [TBITS-1:0] idx;
    bit [63:0] q;
    longint v;
    idx = ph >> (24 - TBITS);
    q = 64'(idx[TBITS-3:0]) << (32 - TBITS);
    if (idx[TBITS-2]) q = (64'd1 << 30) - q;
    v = longint'(quarter_sine_q30(q));
    return idx[TBITS-1] ? -v : v;
  endfunction

  // Sum harmonics below Nyquist, stopping at the cap
  function automatic longint harmonic_sum(logic [1:0] kind, bit [23:0] ph, bit [25:0] f,
                                          inout bit capped);
    longint acc, s, term;
    bit [63:0] h, n, stride;
    acc = 0;
    stride = (kind == bws_pkg::KIND_SAW) ? 64'd1 : 64'd2;
    n = 0;
    forever begin
      h = 64'd1 + stride * n;
      if (!(h * 64'(f) * 64'd2 < 64'(rate_mirror) * 64'd256)) break;
      if (n >= MAX_H) begin
        capped = 1'b1;
        break;
      end
      s = sine_q30(24'((h * 64'(ph)) & PH_MASK));
      if (kind == bws_pkg::KIND_TRI) begin
        term = s / longint'(h * h);
        acc += n[0] ? -term : term;
      end else if (kind == bws_pkg::KIND_SAW) begin
        term = s / longint'(h);
        acc += h[0] ? -term : term;
      end else begin
        acc += s / longint'(h);
      end
      n++;
    end
    return acc;
  endfunction

  // Scale a Q30 sum by a Q30 constant into saturated Q3.20
  function automatic logic [23:0] scale_to_q20(longint total, longint coef);
    longint p, v;
    bit neg;
    bit [63:0] mag;
    p = total * coef;
    neg = p < 0;
    mag = neg ? 64'(-p) : 64'(p);
    mag = (mag + (64'd1 << 39)) >> 40;
    if (mag > (64'd1 << 24)) mag = 64'd1 << 24;
    v = neg ? -longint'(mag) : longint'(mag);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[23:0];
  endfunction

  function automatic wave_result_t wave_sample(wave_item_t it);
    wave_result_t r;
    bit capped;
    bit [15:0] w;
    bit [31:0] off;
    longint d;
    capped = 1'b0;
    r.value = '0;
    case (it.cmd)
      bws_pkg::CMD_SINE:
        r.value = scale_to_q20(sine_q30(it.ph), longint'(bws_pkg::ONE_Q30));
      bws_pkg::CMD_TRIANGLE:
        r.value = scale_to_q20(harmonic_sum(bws_pkg::KIND_TRI, it.ph, it.freq, capped),
                               longint'(bws_pkg::K_TRI));
      bws_pkg::CMD_SAW_UP:
        r.value = scale_to_q20(harmonic_sum(bws_pkg::KIND_SAW, it.ph, it.freq, capped),
                               -longint'(bws_pkg::K_SAW));
      bws_pkg::CMD_SAW_DOWN:
        r.value = scale_to_q20(harmonic_sum(bws_pkg::KIND_SAW, it.ph, it.freq, capped),
                               longint'(bws_pkg::K_SAW));
      bws_pkg::CMD_SQUARE:
        r.value = scale_to_q20(harmonic_sum(bws_pkg::KIND_SQR, it.ph, it.freq, capped),
                               longint'(bws_pkg::K_SQR));
      bws_pkg::CMD_PULSE: begin
        if (it.pw == bws_pkg::PW_HALF) begin
          r.value = scale_to_q20(harmonic_sum(bws_pkg::KIND_SQR, it.ph, it.freq, capped),
                                 longint'(bws_pkg::K_SQR));
        end else begin
          w = it.pw;
          if (w < bws_pkg::PW_MIN) w = bws_pkg::PW_MIN;
          if (w > bws_pkg::PW_MAX) w = bws_pkg::PW_MAX;
          off = 32'(w) << 7;
          d = harmonic_sum(bws_pkg::KIND_SAW, 24'(32'(it.ph) + off), it.freq, capped)
            - harmonic_sum(bws_pkg::KIND_SAW, 24'(32'(it.ph) - off), it.freq, capped);
          r.value = scale_to_q20(d, -longint'(bws_pkg::K_SAW));
        end
      end
      default: r.value = '0;
    endcase
    r.capped = capped;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Drive commands; predict each one at its transfer
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_samples.push_back(wave_sample(cur_item));
      if (!start || !busy) begin
        if (pending_items.size() > 0 && (no_gaps || $urandom_range(99) >= 10)) begin
          cur_item = pending_items.pop_front();
          start <= 1'b1;
          command <= cur_item.cmd;
          phase <= cur_item.ph;
          frequency <= cur_item.freq;
          pulse_width <= cur_item.pw;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    wave_result_t want;
    if (!rst && done) begin
      if (expected_samples.size() == 0) begin
        report_mismatch("result with no command pending");
      end else begin
        want = expected_samples.pop_front();
        if (sample !== want.value)
          report_mismatch($sformatf("sample %h, want %h", sample, want.value));
        if (harmonics_capped !== want.capped)
          report_mismatch($sformatf("capped %b, want %b", harmonics_capped, want.capped));
      end
    end
  end

  task automatic add_item(logic [2:0] c, logic [23:0] p, logic [25:0] f, logic [15:0] w);
    wave_item_t it;
    it.cmd = c;
    it.ph = p;
    it.freq = f;
    it.pw = w;
    pending_items.push_back(it);
  endtask

  // Mostly few harmonics so the run stays short
  task automatic add_random(int count);
    logic [2:0] c;
    logic [25:0] f;
    logic [15:0] w;
    int lo;
    for (int i = 0; i < count; i++) begin
      c = ($urandom_range(99) < 8) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
      if ($urandom_range(3) == 0) c = bws_pkg::CMD_PULSE;
      lo = int'(rate_mirror) * 128 / 24;
      if ($urandom_range(9) < 7) f = 26'($urandom_range(26'h3FFFFFF, lo));
      else f = 26'(int'(rate_mirror) * 128 / $urandom_range(16, 1) - $urandom_range(3));
      w = ($urandom_range(4) == 0) ? bws_pkg::PW_HALF : 16'($urandom);
      add_item(c, 24'($urandom), f, w);
    end
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || start || busy || expected_samples.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_rate(logic [18:0] value);
    sample_rate_we <= 1'b1;
    sample_rate <= value;
    @(posedge clk);
    sample_rate_we <= 1'b0;
    rate_mirror = value;
    @(posedge clk);
  endtask

  // Stimulus
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    add_item(bws_pkg::CMD_SINE, 24'h000000, 26'd0, 16'd0);
    add_item(bws_pkg::CMD_SINE, 24'h400000, 26'd0, 16'd0);
    add_item(bws_pkg::CMD_SINE, 24'h800000, 26'd0, 16'd0);
    add_item(bws_pkg::CMD_SINE, 24'hFFFFFF, 26'h3FFFFFF, 16'hFFFF);
    add_item(bws_pkg::CMD_TRIANGLE, 24'h123456, 26'd112640, 16'd0);
    add_item(bws_pkg::CMD_SAW_UP, 24'h2AAAAA, 26'd112640, 16'd0);
    add_item(bws_pkg::CMD_SAW_DOWN, 24'h2AAAAA, 26'd112640, 16'd0);
    add_item(bws_pkg::CMD_SQUARE, 24'h3FFFFF, 26'd112640, 16'd0);
    add_item(bws_pkg::CMD_PULSE, 24'h100000, 26'd112640, bws_pkg::PW_HALF);
    add_item(bws_pkg::CMD_PULSE, 24'h100000, 26'd500000, 16'd0);
    add_item(bws_pkg::CMD_PULSE, 24'hF00000, 26'd500000, 16'hFFFF);
    add_item(bws_pkg::CMD_PULSE, 24'h555555, 26'd500000, bws_pkg::PW_MIN);
    add_item(bws_pkg::CMD_PULSE, 24'h555555, 26'd500000, bws_pkg::PW_MAX);
    add_item(bws_pkg::CMD_PULSE, 24'h000001, 26'd500000, 16'd1000);
    add_item(bws_pkg::CMD_PULSE, 24'h7FFFFF, 26'd500000, 16'd32767);
    add_item(3'd6, 24'hABCDEF, 26'd112640, 16'd0);
    add_item(3'd7, 24'hFFFFFF, 26'h3FFFFFF, 16'hFFFF);
    add_item(bws_pkg::CMD_SAW_UP, 24'h400000, 26'h3FFFFFF, 16'd0);
    add_item(bws_pkg::CMD_SQUARE, 24'h200000, 26'd6143999, 16'd0);
    // harmonic cap: frequency zero and very low fundamentals
    add_item(bws_pkg::CMD_TRIANGLE, 24'h0F0F0F, 26'd0, 16'd0);
    add_item(bws_pkg::CMD_SAW_DOWN, 24'h333333, 26'd0, 16'd0);
    add_item(bws_pkg::CMD_SQUARE, 24'h6789AB, 26'd1, 16'd0);
    add_item(bws_pkg::CMD_PULSE, 24'h13579B, 26'd256, 16'd100);
    add_random(60);
    drain();
    write_rate(19'd8000);
    add_random(50);
    drain();
    no_gaps = 1'b1;
    write_rate(19'd384000);
    add_random(50);
    drain();
    no_gaps = 1'b0;
    write_rate(19'h7FFFF);
    add_random(40);
    drain();
    // zero rate: no harmonic is ever below Nyquist
    write_rate(19'd0);
    add_item(bws_pkg::CMD_TRIANGLE, 24'h111111, 26'd0, 16'd0);
    add_random(30);
    drain();
    write_rate(19'($urandom_range(384000, 8000)));
    add_random(35);
    drain();
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Timeout
  initial begin
    #50_000_000;
    $display("tb failed");
    $finish;
  end

endmodule
